>>> sv/cfks_pkg.sv
// shared types and constants for the circular fifo with key search
// no dependencies; imported by cfks_ctrl, cfks_dp and the core top level
package cfks_pkg;

  localparam int DEPTH        = 16;
  localparam int KEY_BYTES    = 8;
  localparam int PAYLOAD_BITS = 32;

  localparam int KEY_W = 8 * KEY_BYTES;
  localparam int PAY_W = (PAYLOAD_BITS < 32) ? PAYLOAD_BITS : 32;
  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  typedef enum logic [2:0] {
    MODE_ENQ        = 3'd0,
    MODE_DEQ        = 3'd1,
    MODE_PEEK_FRONT = 3'd2,
    MODE_PEEK_LAST  = 3'd3,
    MODE_SEARCH     = 3'd4
  } mode_e_t;

  typedef struct packed {
    logic [2:0]  mode;
    logic [63:0] key;
    logic [31:0] payload;
  } req_t;

  typedef struct packed {
    logic        ok;
    logic [63:0] entry_key;
    logic [31:0] entry_payload;
    logic [3:0]  position;
    logic [4:0]  count;
  } rsp_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_READ,
    ST_SCAN,
    ST_RESP
  } state_t;

  typedef enum logic [1:0] {
    RD_HEAD,
    RD_LAST,
    RD_NEXT
  } rd_sel_t;

  typedef enum logic [2:0] {
    RES_HOLD,
    RES_FAIL,
    RES_DONE,
    RES_ENTRY,
    RES_MATCH
  } res_op_t;

  typedef struct packed {
    logic    load_req;
    logic    wr_en;
    logic    rd_en;
    rd_sel_t rd_sel;
    logic    scan_start;
    logic    scan_step;
    logic    deq;
    res_op_t res_op;
  } cmd_t;

  typedef struct packed {
    logic [2:0] mode;
    logic       full;
    logic       empty;
    logic       match;
    logic       scan_last;
  } sts_t;

endpackage

>>> sv/circular_fifo_with_key_search_core.sv
// top level of the circular fifo with key search
// depends on cfks_pkg, cfks_ctrl and cfks_dp
//
//   channel  handshake            payload
//   req      req_valid/req_stall  req (mode, key, payload)
//   rsp      rsp_valid/rsp_stall  rsp (ok, entry_key, entry_payload, position, count)
//
// one request at a time: req_stall is low only while idle
// enqueue and refused requests: the result turns valid in ST_RESP, after ST_EXEC
// dequeue and peeks: ST_EXEC, then ST_READ, then ST_RESP, one registered read of the entry memory
// search: ST_EXEC, then ST_SCAN with entries compared one per cycle through the read port, then ST_RESP
// with no stall the result beat is taken in the same cycle as it turns valid
// rst is synchronous and clears pointers, count and the controller, not the memory
// a stalled result holds until taken; the next request is accepted the cycle after
module circular_fifo_with_key_search_core (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_stall,
  input  cfks_pkg::req_t req,
  output logic           rsp_valid,
  input  logic           rsp_stall,
  output cfks_pkg::rsp_t rsp
);
  import cfks_pkg::*;

  cmd_t cmd;
  sts_t sts;

  cfks_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  cfks_dp u_dp (
    .clk (clk),
    .rst (rst),
    .req (req),
    .cmd (cmd),
    .sts (sts),
    .rsp (rsp)
  );

endmodule

>>> sv/cfks_ctrl.sv
// controller state machine for the circular fifo with key search
// depends on cfks_pkg; drives cfks_dp through cmd_t, reads sts_t back
module cfks_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_stall,
  output logic           rsp_valid,
  input  logic           rsp_stall,
  input  cfks_pkg::sts_t sts,
  output cfks_pkg::cmd_t cmd
);
  import cfks_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next     = state;
    req_stall      = 1'b1;
    rsp_valid      = 1'b0;
    cmd            = '0;
    cmd.rd_sel     = RD_HEAD;
    cmd.res_op     = RES_HOLD;
    case (state)
      ST_IDLE: begin
        req_stall = 1'b0;
        if (req_valid) begin
          cmd.load_req = 1'b1;
          state_next   = ST_EXEC;
        end
      end
      ST_EXEC: begin
        state_next = ST_RESP;
        case (sts.mode)
          MODE_ENQ: begin
            if (sts.full) begin
              cmd.res_op = RES_FAIL;
            end else begin
              cmd.wr_en  = 1'b1;
              cmd.res_op = RES_DONE;
            end
          end
          MODE_DEQ, MODE_PEEK_FRONT, MODE_PEEK_LAST: begin
            if (sts.empty) begin
              cmd.res_op = RES_FAIL;
            end else begin
              cmd.rd_en  = 1'b1;
              cmd.rd_sel = (sts.mode == MODE_PEEK_LAST) ? RD_LAST : RD_HEAD;
              state_next = ST_READ;
            end
          end
          MODE_SEARCH: begin
            if (sts.empty) begin
              cmd.res_op = RES_FAIL;
            end else begin
              cmd.rd_en      = 1'b1;
              cmd.rd_sel     = RD_HEAD;
              cmd.scan_start = 1'b1;
              state_next     = ST_SCAN;
            end
          end
          default: begin
            cmd.res_op = RES_FAIL;
          end
        endcase
      end
      ST_READ: begin
        cmd.res_op = RES_ENTRY;
        cmd.deq    = (sts.mode == MODE_DEQ);
        state_next = ST_RESP;
      end
      ST_SCAN: begin
        // read data in hand belongs to the current offset; next read is already chained
        if (sts.match) begin
          cmd.res_op = RES_MATCH;
          state_next = ST_RESP;
        end else if (sts.scan_last) begin
          cmd.res_op = RES_FAIL;
          state_next = ST_RESP;
        end else begin
          cmd.rd_en     = 1'b1;
          cmd.rd_sel    = RD_NEXT;
          cmd.scan_step = 1'b1;
        end
      end
      ST_RESP: begin
        rsp_valid = 1'b1;
        if (!rsp_stall) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

>>> sv/cfks_dp.sv
// datapath for the circular fifo with key search: entry memory, ring
// pointers, fill count, scan offset and result register; depends on cfks_pkg
module cfks_dp (
  input  logic           clk,
  input  logic           rst,
  input  cfks_pkg::req_t req,
  input  cfks_pkg::cmd_t cmd,
  output cfks_pkg::sts_t sts,
  output cfks_pkg::rsp_t rsp
);
  import cfks_pkg::*;

  logic [KEY_W-1:0] key_mem [DEPTH];
  logic [PAY_W-1:0] pay_mem [DEPTH];

  logic [2:0]       req_mode;
  logic [KEY_W-1:0] req_key;
  logic [PAY_W-1:0] req_pay;

  logic [IDX_W-1:0] head;
  logic [IDX_W-1:0] tail;
  logic [CNT_W-1:0] count;

  logic [IDX_W-1:0] scan_addr;
  logic [IDX_W-1:0] scan_off;
  logic [IDX_W-1:0] rd_addr;
  logic [KEY_W-1:0] rd_key;
  logic [PAY_W-1:0] rd_pay;

  logic             res_ok;
  logic [63:0]      res_key;
  logic [31:0]      res_pay;
  logic [3:0]       res_pos;

  function automatic logic [IDX_W-1:0] ring_next(input logic [IDX_W-1:0] i);
    return (i == IDX_W'(DEPTH - 1)) ? '0 : i + 1'b1;
  endfunction

  function automatic logic [IDX_W-1:0] ring_prev(input logic [IDX_W-1:0] i);
    return (i == '0) ? IDX_W'(DEPTH - 1) : i - 1'b1;
  endfunction

  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      req_mode <= req.mode;
      req_key  <= req.key[KEY_W-1:0];
      req_pay  <= req.payload[PAY_W-1:0];
    end
  end

  always_comb begin
    case (cmd.rd_sel)
      RD_HEAD: rd_addr = head;
      RD_LAST: rd_addr = ring_prev(tail);
      RD_NEXT: rd_addr = ring_next(scan_addr);
      default: rd_addr = head;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      key_mem[tail] <= req_key;
      pay_mem[tail] <= req_pay;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      rd_key    <= key_mem[rd_addr];
      rd_pay    <= pay_mem[rd_addr];
      scan_addr <= rd_addr;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_start) begin
      scan_off <= '0;
    end else if (cmd.scan_step) begin
      scan_off <= scan_off + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else if (cmd.wr_en) begin
      tail  <= ring_next(tail);
      count <= count + 1'b1;
    end else if (cmd.deq) begin
      head  <= ring_next(head);
      count <= count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.res_op)
      RES_FAIL: begin
        res_ok  <= 1'b0;
        res_key <= '0;
        res_pay <= '0;
        res_pos <= '0;
      end
      RES_DONE: begin
        res_ok  <= 1'b1;
        res_key <= '0;
        res_pay <= '0;
        res_pos <= '0;
      end
      RES_ENTRY: begin
        res_ok  <= 1'b1;
        res_key <= 64'(rd_key);
        res_pay <= 32'(rd_pay);
        res_pos <= '0;
      end
      RES_MATCH: begin
        res_ok  <= 1'b1;
        res_key <= '0;
        res_pay <= '0;
        res_pos <= 4'(scan_off);
      end
      default: begin
      end
    endcase
  end

  assign sts.mode      = req_mode;
  assign sts.full      = (count == CNT_W'(DEPTH));
  assign sts.empty     = (count == '0);
  assign sts.match     = (rd_key == req_key);
  assign sts.scan_last = ((CNT_W'(scan_off) + 1'b1) == count);

  assign rsp.ok            = res_ok;
  assign rsp.entry_key     = res_key;
  assign rsp.entry_payload = res_pay;
  assign rsp.position      = res_pos;
  assign rsp.count         = 5'(count);

endmodule
